// ===== sv/lir_pkg.sv =====
`default_nettype none

package lir_pkg;

  // Sample and count widths.
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 12;
  localparam int CNT_W       = COUNT_BITS + 1;          // holds 2^COUNT_BITS
  localparam int COUNT_LIMIT = 1 << COUNT_BITS;
  localparam int POS_W       = COUNT_BITS;
  localparam int IDX_W       = COUNT_BITS + 1;
  localparam int PHASE_W     = 2 * COUNT_BITS;

  // Run cap and its counter.
  localparam int MAX_RUN = 64;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);

  // Interpolation datapath widths.
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + CNT_W + 1;
  localparam int T_W    = PROD_W + 1;
  localparam int DIV_W  = SAMPLE_BITS + COUNT_BITS + 1;  // magnitude of the dividend
  localparam int Q_W    = SAMPLE_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd100;

endpackage

`default_nettype wire

// ===== sv/linear_interp_resampler_core.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  sample_i
// out       source     out_valid_o/out_stall_i value_o, last_of_run_o, end_of_block_o,
//                                              run_capped_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The block takes one sample at a time and is stalled until all its results are loaded.
// When N equals M a sample passes straight through. Otherwise a sample first scans up to 65
// due outputs, then each result goes through the multiplier and the bit-serial divider
// (one quotient bit per cycle); dropped outputs are counted without being computed.
// Reset is asynchronous and active low; the output register lets the last result
// of a sample wait while the next sample is accepted.
module linear_interp_resampler_core import lir_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      value_o,
  output logic                               last_of_run_o,
  output logic                               end_of_block_o,
  output logic                               run_capped_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CNT_W-1:0]              cfg_data_i
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PASS  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_RUN   = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_DSTRT = 8'b0010_0000,
    ST_DWAIT = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]              n_reg_q, m_reg_q;
  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic signed [SAMPLE_BITS-1:0] samp_q, samp_d;
  logic signed [DIFF_W-1:0]      diff_q, diff_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [PHASE_W-1:0]            phase_q, phase_d;
  logic [PHASE_W-1:0]            base_q, base_d;
  logic [IDX_W-1:0]              scan_idx_q, scan_idx_d;
  logic [PHASE_W-1:0]            scan_phase_q, scan_phase_d;
  logic [RUN_W-1:0]              scan_cnt_q, scan_cnt_d;
  logic [RUN_W-1:0]              emit_cnt_q, emit_cnt_d;
  logic                          capped_q, capped_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [SAMPLE_BITS-1:0] val_q, val_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic                          last_q, last_d;
  logic                          eob_q, eob_d;
  logic                          ocap_q, ocap_d;

  logic [CNT_W-1:0]   n_eff, m_eff, half_m;
  logic [POS_W-1:0]   nm1;
  logic               pass_mode;
  logic [PHASE_W-1:0] limit;
  logic               due, scan_due, next_due;
  logic [IDX_W-1:0]   idx_inc;
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W-1:0] r_full;
  logic [CNT_W-1:0]   r_frac;
  logic [CNT_W:0]     pos_inc;
  logic               in_accept, out_free, cfg_write;
  logic signed [T_W-1:0] t_val, t_abs;
  logic               div_start, div_done;
  logic signed [Q_W-1:0] div_quot;
  logic signed [Q_W:0]   val_sum;

  // Effective counts, saturated to their legal ranges.
  always_comb begin
    n_eff = n_reg_q;
    if (n_reg_q < CNT_W'(2)) n_eff = CNT_W'(2);
    if (n_reg_q > CNT_W'(COUNT_LIMIT)) n_eff = CNT_W'(COUNT_LIMIT);
    m_eff = m_reg_q;
    if (m_reg_q < CNT_W'(1)) m_eff = CNT_W'(1);
    if (m_reg_q > CNT_W'(COUNT_LIMIT)) m_eff = CNT_W'(COUNT_LIMIT);
  end

  assign nm1       = POS_W'(n_eff - 1'b1);
  assign half_m    = m_eff >> 1;
  assign pass_mode = n_eff == m_eff;

  // Interval bounds and the due tests for the scan and run pointers.
  assign limit     = base_q + PHASE_W'(m_eff);
  assign due       = (idx_q < m_eff) && (phase_q <= limit);
  assign scan_due  = (scan_idx_q < m_eff) && (scan_phase_q <= limit);
  assign idx_inc   = idx_q + 1'b1;
  assign phase_inc = phase_q + PHASE_W'(nm1);
  assign next_due  = (idx_inc < m_eff) && (phase_inc <= limit);
  assign r_full    = phase_q - base_q;
  assign r_frac    = r_full[CNT_W-1:0];
  assign pos_inc   = {1'b0, pos_q} + 1'b1;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_write  = cfg_valid_i && cfg_ready_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // Rounding numerator d*r + M/2, split into sign and magnitude for the divider.
  assign t_val     = T_W'(prod_q) + $signed({{(T_W-CNT_W){1'b0}}, half_m});
  assign t_abs     = t_val[T_W-1] ? -t_val : t_val;
  assign div_start = state_q == ST_DSTRT;
  assign val_sum   = (Q_W+1)'(prev_q) + (Q_W+1)'(div_quot);

  lir_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (t_abs[DIV_W-1:0]),
    .divisor_i  (m_eff),
    .neg_i      (t_val[T_W-1]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    samp_d       = samp_q;
    diff_d       = diff_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    base_d       = base_q;
    scan_idx_d   = scan_idx_q;
    scan_phase_d = scan_phase_q;
    scan_cnt_d   = scan_cnt_q;
    emit_cnt_d   = emit_cnt_q;
    capped_d     = capped_q;
    prod_d       = prod_q;
    val_d        = val_q;
    out_valid_d  = out_valid_q && out_stall_i;
    value_d      = value_q;
    last_d       = last_q;
    eob_d        = eob_q;
    ocap_d       = ocap_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          samp_d = sample_i;
          diff_d = DIFF_W'(sample_i) - DIFF_W'(prev_q);
          if (pass_mode) begin
            state_d = ST_PASS;
          end else if (pos_q == '0) begin
            prev_d = sample_i;
            pos_d  = POS_W'(1);
          end else begin
            scan_idx_d   = idx_q;
            scan_phase_d = phase_q;
            scan_cnt_d   = '0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = samp_q;
          last_d      = 1'b1;
          eob_d       = pos_q >= nm1;
          ocap_d      = 1'b0;
          prev_d      = samp_q;
          pos_d       = (pos_inc >= n_eff) ? '0 : pos_inc[POS_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Count due outputs until the cap is passed or none is left.
        emit_cnt_d = '0;
        if (scan_due && scan_cnt_q == RUN_W'(MAX_RUN)) begin
          capped_d = 1'b1;
          state_d  = ST_RUN;
        end else if (scan_due) begin
          scan_cnt_d   = scan_cnt_q + 1'b1;
          scan_idx_d   = scan_idx_q + 1'b1;
          scan_phase_d = scan_phase_q + PHASE_W'(nm1);
        end else begin
          capped_d = 1'b0;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!due) begin
          prev_d = samp_q;
          if (pos_inc >= n_eff) begin
            pos_d   = '0;
            idx_d   = '0;
            phase_d = '0;
            base_d  = '0;
          end else begin
            pos_d  = pos_inc[POS_W-1:0];
            base_d = limit;
          end
          state_d = ST_IDLE;
        end else if (emit_cnt_q == RUN_W'(MAX_RUN)) begin
          // Past the cap: the output is dropped but still counted.
          idx_d   = idx_inc;
          phase_d = phase_inc;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = diff_q * $signed({1'b0, r_frac});
        state_d = ST_DSTRT;
      end
      ST_DSTRT: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          val_d   = val_sum[SAMPLE_BITS-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = val_q;
          last_d      = (emit_cnt_q == RUN_W'(MAX_RUN - 1)) || !next_due;
          eob_d       = idx_q == (m_eff - 1'b1);
          ocap_d      = capped_q;
          idx_d       = idx_inc;
          phase_d     = phase_inc;
          emit_cnt_d  = emit_cnt_q + 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write restarts the block.
    if (cfg_write && (cfg_index_i == CFG_INPUT_COUNT || cfg_index_i == CFG_OUTPUT_COUNT)) begin
      pos_d   = '0;
      idx_d   = '0;
      phase_d = '0;
      base_d  = '0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_reg_q     <= COUNT_RESET;
      m_reg_q     <= COUNT_RESET;
      prev_q      <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      phase_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      if (cfg_write && cfg_index_i == CFG_INPUT_COUNT) n_reg_q <= cfg_data_i;
      if (cfg_write && cfg_index_i == CFG_OUTPUT_COUNT) m_reg_q <= cfg_data_i;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    samp_q       <= samp_d;
    diff_q       <= diff_d;
    scan_idx_q   <= scan_idx_d;
    scan_phase_q <= scan_phase_d;
    scan_cnt_q   <= scan_cnt_d;
    emit_cnt_q   <= emit_cnt_d;
    capped_q     <= capped_d;
    prod_q       <= prod_d;
    val_q        <= val_d;
    value_q      <= value_d;
    last_q       <= last_d;
    eob_q        <= eob_d;
    ocap_q       <= ocap_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign last_of_run_o  = last_q;
  assign end_of_block_o = eob_q;
  assign run_capped_o   = ocap_q;

endmodule

`default_nettype wire

// ===== sv/lir_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, with floor correction
// for a negative dividend given as sign and magnitude.
module lir_div import lir_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_W-1:0]     dividend_i,
  input  wire logic [CNT_W-1:0]     divisor_i,
  input  wire logic                 neg_i,
  output logic                      done_o,
  output logic signed [Q_W-1:0]     quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     div_q, div_d;
  logic                 neg_q, neg_d;

  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;
  logic signed [Q_W-1:0] mag;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = neg_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // Floor quotient: a negative dividend with a remainder rounds down by one.
  assign mag    = $signed(quo_q[Q_W-1:0]);
  assign quot_o = neg_q ? (-mag - $signed({{(Q_W-1){1'b0}}, rem_q != '0})) : mag;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== tb/sv/linear_interp_resampler_core_tb.sv =====
`default_nettype none

module linear_interp_resampler_core_tb import lir_pkg::*; ();

  localparam int TARGET_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 5000;
  localparam int CYCLE_LIMIT   = 20_000_000;

  // Indexes that select no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_of_run;
    logic                          end_of_block;
    logic                          run_capped;
  } resampled_t;

  // Tracks the converter state, predicts the outputs of each sample and checks them.
  class resample_scoreboard;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] m_reg;
    longint           prev_sample;
    longint           sample_pos;
    longint           out_index;
    longint           phase_num;
    resampled_t       due_outputs[$];
    int               mismatches;
    int               checked;
    int               capped_runs;

    function new();
      n_reg       = COUNT_RESET;
      m_reg       = COUNT_RESET;
      prev_sample = 0;
      sample_pos  = 0;
      out_index   = 0;
      phase_num   = 0;
      mismatches  = 0;
      checked     = 0;
      capped_runs = 0;
    endfunction

    function longint clamp_count(logic [CNT_W-1:0] v, longint lo);
      if (v < lo) return lo;
      if (v > COUNT_LIMIT) return COUNT_LIMIT;
      return v;
    endfunction

    // A write to a real register restarts the block but keeps the previous sample.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      case (idx)
        CFG_INPUT_COUNT:  n_reg = data;
        CFG_OUTPUT_COUNT: m_reg = data;
        default: return;
      endcase
      sample_pos = 0;
      out_index  = 0;
      phase_num  = 0;
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
      longint     n;
      longint     m;
      longint     cur;
      longint     step;
      longint     lim;
      longint     base;
      longint     num;
      longint     q;
      bit         capped;
      resampled_t run[$];
      resampled_t res;
      n      = clamp_count(n_reg, 2);
      m      = clamp_count(m_reg, 1);
      cur    = s;
      capped = 1'b0;

      // Equal counts pass every sample straight through.
      if (n == m) begin
        res.value        = s;
        res.last_of_run  = 1'b1;
        res.end_of_block = (sample_pos >= n - 1);
        res.run_capped   = 1'b0;
        due_outputs = {due_outputs, res};
        sample_pos  = (sample_pos + 1 >= n) ? 0 : sample_pos + 1;
        out_index   = sample_pos;
        phase_num   = out_index * (n - 1);
        prev_sample = cur;
        return;
      end

      // The first sample of a block only opens the first interval.
      if (sample_pos == 0) begin
        prev_sample = cur;
        sample_pos  = 1;
        return;
      end

      // Emit every output whose position falls at or before this sample.
      lim  = sample_pos * m;
      base = (sample_pos - 1) * m;
      step = cur - prev_sample;
      while (out_index < m && phase_num <= lim) begin
        if (run.size() < MAX_RUN) begin
          num = prev_sample * m + step * (phase_num - base) + m / 2;
          q   = num / m;
          if (num % m != 0 && num < 0) q = q - 1;
          res.value        = q[SAMPLE_BITS-1:0];
          res.last_of_run  = 1'b0;
          res.end_of_block = (out_index == m - 1);
          res.run_capped   = 1'b0;
          run = {run, res};
        end else begin
          capped = 1'b1;
        end
        out_index = out_index + 1;
        phase_num = phase_num + (n - 1);
      end

      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      if (capped) begin
        capped_runs++;
        foreach (run[k]) run[k].run_capped = 1'b1;
      end
      foreach (run[k]) due_outputs = {due_outputs, run[k]};

      sample_pos = sample_pos + 1;
      if (sample_pos >= n) begin
        sample_pos = 0;
        out_index  = 0;
        phase_num  = 0;
      end
      prev_sample = cur;
    endfunction

    function void flag(string msg);
      mismatches++;
      $display("%0t: output %0d: %s", $time, checked, msg);
    endfunction

    function void check_result(logic signed [SAMPLE_BITS-1:0] v, logic lr, logic eb,
                               logic rc);
      resampled_t want;
      if (due_outputs.size() == 0) begin
        flag($sformatf("expected no output, got value %0d last %b end %b capped %b",
                       v, lr, eb, rc));
        return;
      end
      want = due_outputs.pop_front();
      checked++;
      if (v !== want.value)
        flag($sformatf("value: expected %0d, got %0d", $signed(want.value), v));
      if (lr !== want.last_of_run)
        flag($sformatf("last_of_run: expected %b, got %b", want.last_of_run, lr));
      if (eb !== want.end_of_block)
        flag($sformatf("end_of_block: expected %b, got %b", want.end_of_block, eb));
      if (rc !== want.run_capped)
        flag($sformatf("run_capped: expected %b, got %b", want.run_capped, rc));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SAMPLE_BITS-1:0] value_o;
  logic                          last_of_run_o;
  logic                          end_of_block_o;
  logic                          run_capped_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CNT_W-1:0]              cfg_data_i;

  resample_scoreboard            tracker;
  bit                            src_steady;
  bit                            sink_steady;
  int                            items_sent;
  int                            settings_used;
  int                            cycle_count = 0;
  logic signed [SAMPLE_BITS-1:0] last_sample;

  linear_interp_resampler_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_block_o (end_of_block_o),
    .run_capped_o   (run_capped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d outputs still due", $time, tracker.due_outputs.size());
      $display("linear_interp_resampler_core_tb: FAIL");
      $finish;
    end
  end

  // Output side: stall a random number of cycles before each item, then take and check it.
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      tracker.check_result(value_o, last_of_run_o, end_of_block_o, run_capped_o);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_sample(s);
    items_sent++;
    last_sample = s;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every due output has arrived, then let dropped outputs and a
  // stored first sample finish inside the block.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.due_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CNT_W-1:0] n_val, input logic [CNT_W-1:0] m_val);
    settle();
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_INPUT_COUNT, n_val);
      cfg_write(CFG_OUTPUT_COUNT, m_val);
    end else begin
      cfg_write(CFG_OUTPUT_COUNT, m_val);
      cfg_write(CFG_INPUT_COUNT, n_val);
    end
    settings_used++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      logic signed [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return prev + SAMPLE_BITS'($urandom_range(0, 16)) - SAMPLE_BITS'(8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // One random count setting followed by a stream of random samples.
  task automatic random_phase();
    int               kind;
    int               count;
    logic [CNT_W-1:0] n_val;
    logic [CNT_W-1:0] m_val;
    kind  = $urandom_range(0, 9);
    count = $urandom_range(15, 35);
    case (kind)
      6: begin
        n_val = CNT_W'($urandom_range(2, 16));
        m_val = n_val;
      end
      7: begin
        // Upsampling that can be steep enough to overflow the run.
        n_val = CNT_W'($urandom_range(2, 3));
        m_val = CNT_W'($urandom_range(65, 300));
        count = $urandom_range(4, 8);
      end
      8: begin
        n_val = CNT_W'($urandom_range(2, 300));
        m_val = CNT_W'($urandom_range(1, 64));
      end
      9: begin
        n_val = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 1))
                                     : CNT_W'($urandom_range(4097, 8191));
        m_val = $urandom_range(0, 1) ? '0 : CNT_W'($urandom_range(1, 24));
      end
      default: begin
        n_val = CNT_W'($urandom_range(2, 12));
        m_val = CNT_W'($urandom_range(1, 24));
      end
    endcase
    configure(n_val, m_val);
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    repeat (count) send_sample(pick_sample(last_sample));
  endtask

  initial begin : stimulus
    tracker       = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    out_stall_i   = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_INPUT_COUNT;
    cfg_data_i    = '0;
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    last_sample   = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset counts are equal, so samples pass through unchanged.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd0);
    send_sample(-16'sd1);

    // Half-step outputs round ties upward; an exact hit uses the full fraction.
    // A write to a spare index in mid-block must not restart the block.
    configure(13'd3, 13'd4);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    settle();
    cfg_write(CFG_SPARE_2, 13'd5);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    // Counts below and above range saturate: N = 2, M = 4096 overflows the run
    // and drops every output of the block past the first 64.
    configure(13'd0, 13'd8191);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd5);

    // N = 4096, M = 1: a single output per block, then nothing more is due.
    configure(13'd8191, 13'd0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd7);

    // Largest pass-through, again with a spare-index write in mid-block.
    configure(13'd4096, 13'd4096);
    send_sample(16'sd12345);
    send_sample(SAMPLE_MIN);
    settle();
    cfg_write(CFG_SPARE_3, 13'h1FFF);
    send_sample(16'sd3);

    // Exactly a full run, then one output more than a run can hold.
    configure(13'd1, 13'd64);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    configure(13'd2, 13'd65);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    while (items_sent < TARGET_ITEMS) random_phase();

    settle();
    $display("Resampled %0d samples into %0d checked outputs over %0d count settings.",
             items_sent, tracker.checked, settings_used);
    $display("%0d sample runs overflowed and were capped.", tracker.capped_runs);
    if (tracker.mismatches == 0 && tracker.due_outputs.size() == 0) begin
      $display("linear_interp_resampler_core_tb: PASS");
    end else begin
      $display("linear_interp_resampler_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/lir_pkg.sv
sv/lir_div.sv
sv/linear_interp_resampler_core.sv
tb/sv/linear_interp_resampler_core_tb.sv
